// ===== hdl/cidr_pkg.sv =====
// Shared types and constants for the IPv4 CIDR validator.
// No dependencies; cidr_step, cidr_verdict and ipv4_cidr_validator_core import this package.
`default_nettype none

package cidr_pkg;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Octet and prefix limits
  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [8:0] OCTET_SAT  = 9'd256;
  localparam logic [5:0] PREFIX_MAX = 6'd32;
  localparam logic [5:0] PREFIX_SAT = 6'd33;
  localparam logic [1:0] LAST_OCTET = 2'd3;

  // Parser state carried from one character to the next
  typedef struct packed {
    logic        in_prefix;
    logic [1:0]  octet_count;
    logic [8:0]  octet_value;
    logic [1:0]  octet_digits;
    logic        octet_leading_zero;
    logic [31:0] address_shift;
    logic [5:0]  prefix_value;
    logic        prefix_seen_digit;
    logic        error_seen;
  } cidr_state_t;

  // One result word
  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
    logic [5:0]  prefix_len;
  } cidr_result_t;

  // An octet may close: nonempty, no leading zero unless it is a lone 0, at most 255
  function automatic logic octet_ok(input cidr_state_t s);
    octet_ok = (s.octet_digits != 2'd0)
            && !(s.octet_leading_zero && (s.octet_digits >= 2'd2))
            && (s.octet_value <= OCTET_MAX);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cidr_char_if.sv =====
// Character channel: one text byte per word plus an end-of-text mark.
// No dependencies.
`default_nettype none

interface cidr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/cidr_result_if.sv =====
// Result channel: verdict, address and prefix length per word.
// No dependencies.
`default_nettype none

interface cidr_result_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;
  logic [5:0]  prefix_len;

  modport source (output valid, output valid_res, output address, output prefix_len,
                  input ready);
  modport sink   (input valid, input valid_res, input address, input prefix_len,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/cidr_step.sv =====
// Per-character parser update: current state and one byte give the next state.
// Depends on cidr_pkg.
`default_nettype none

module cidr_step (
  input  cidr_pkg::cidr_state_t state,
  input  logic [7:0]            character,
  output cidr_pkg::cidr_state_t state_next
);
  import cidr_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] octet_acc;
  logic [8:0]  prefix_acc;
  logic        close_ok;

  assign is_digit   = (character >= CH_ZERO) && (character <= CH_NINE);
  assign digit      = character[3:0];
  assign octet_acc  = {3'b000, state.octet_value} * 12'd10 + {8'h00, digit};
  assign prefix_acc = {3'b000, state.prefix_value} * 9'd10 + {5'b00000, digit};
  assign close_ok   = octet_ok(state);

  // Advance the parser; once an error is seen, hold everything
  always_comb begin
    state_next = state;
    if (!state.error_seen) begin
      if (!state.in_prefix) begin
        if (is_digit) begin
          if ((state.octet_digits == 2'd0) && (digit == 4'd0)) begin
            state_next.octet_leading_zero = 1'b1;
          end
          state_next.octet_value = (octet_acc > {3'b000, OCTET_MAX}) ? OCTET_SAT
                                                                      : octet_acc[8:0];
          if (state.octet_digits < 2'd2) begin
            state_next.octet_digits = state.octet_digits + 2'd1;
          end
        end else if (character == CH_DOT) begin
          if (state.octet_count == LAST_OCTET) begin
            state_next.error_seen = 1'b1;
          end else begin
            if (close_ok) begin
              state_next.address_shift = {state.address_shift[23:0], state.octet_value[7:0]};
              state_next.octet_count   = state.octet_count + 2'd1;
            end else begin
              state_next.error_seen = 1'b1;
            end
            state_next.octet_value        = '0;
            state_next.octet_digits       = '0;
            state_next.octet_leading_zero = 1'b0;
          end
        end else if (character == CH_SLASH) begin
          if (state.octet_count != LAST_OCTET) begin
            state_next.error_seen = 1'b1;
          end else begin
            if (close_ok) begin
              state_next.address_shift = {state.address_shift[23:0], state.octet_value[7:0]};
              state_next.in_prefix     = 1'b1;
            end else begin
              state_next.error_seen = 1'b1;
            end
            state_next.octet_value        = '0;
            state_next.octet_digits       = '0;
            state_next.octet_leading_zero = 1'b0;
          end
        end else begin
          state_next.error_seen = 1'b1;
        end
      end else begin
        if (is_digit) begin
          state_next.prefix_value = (prefix_acc > {3'b000, PREFIX_MAX}) ? PREFIX_SAT
                                                                         : prefix_acc[5:0];
          state_next.prefix_seen_digit = 1'b1;
        end else begin
          state_next.error_seen = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cidr_verdict.sv =====
// End-of-text check: closes the last octet, checks prefix and host bits.
// Depends on cidr_pkg.
`default_nettype none

module cidr_verdict (
  input  cidr_pkg::cidr_state_t  state,
  output cidr_pkg::cidr_result_t result
);
  import cidr_pkg::*;

  logic        ok;
  logic [31:0] addr;
  logic [5:0]  plen;
  logic [31:0] tail_mask;

  // Finish the address or the prefix, whichever part the text ended in
  always_comb begin
    ok   = !state.error_seen;
    addr = state.address_shift;
    plen = PREFIX_MAX;
    if (ok && !state.in_prefix) begin
      ok   = (state.octet_count == LAST_OCTET) && octet_ok(state);
      addr = {state.address_shift[23:0], state.octet_value[7:0]};
    end else if (ok) begin
      ok   = state.prefix_seen_digit && (state.prefix_value >= 6'd1)
          && (state.prefix_value <= PREFIX_MAX);
      plen = state.prefix_value;
    end
  end

  // Reject a zero address or an address with host bits set
  assign tail_mask = (plen >= PREFIX_MAX) ? 32'h0000_0000 : (32'hFFFF_FFFF >> plen[4:0]);

  always_comb begin
    result = '0;
    if (ok && (addr != 32'h0000_0000) && ((addr & tail_mask) == 32'h0000_0000)) begin
      result.valid_res  = 1'b1;
      result.address    = addr;
      result.prefix_len = plen;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ipv4_cidr_validator_core.sv =====
// IPv4 CIDR validator: usage notes
//
// chars   : sink of text words, one ASCII byte each; is_last marks the end of a text.
// results : source of one word per text (valid_res, address, prefix_len); address
//           and prefix_len are zero when the text is not a canonical nonzero CIDR.
// A word moves when valid and ready are both high at a rising edge of clk.
//
// Throughput: one character per cycle unless a result stalls; texts follow with no gap.
// Path: a taken character waits in the input register, then the parse and check logic
// loads the result register; a last character waits there while the earlier result is
// not yet taken. The per-character update plus the end-of-text check is the single
// logic stage between those two registers.
//
// Reset (rst, synchronous): empties the input and result registers, holds chars.ready
// low and returns the parser to the start of a text.
// Stall: while a result waits for results.ready, characters keep being taken until a
// second last character reaches the input register; that one holds, and chars.ready
// falls, until the waiting result is taken.
// Depends on cidr_pkg, cidr_char_if, cidr_result_if, cidr_step, cidr_verdict.
`default_nettype none

module ipv4_cidr_validator_core (
  input  wire           clk,
  input  wire           rst,
  cidr_char_if.sink     chars,
  cidr_result_if.source results
);
  import cidr_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_character;
  logic         s1_last;
  logic         s1_advance;
  cidr_state_t  state;
  cidr_state_t  state_next;
  cidr_result_t result_next;

  // A last character needs a free result register; others always move on
  assign s1_advance  = s1_valid && (!s1_last || !results.valid || results.ready);
  assign chars.ready = !rst && (!s1_valid || s1_advance);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s1_character <= chars.character;
      s1_last      <= chars.is_last;
    end
  end

  cidr_step u_step (
    .state      (state),
    .character  (s1_character),
    .state_next (state_next)
  );

  cidr_verdict u_verdict (
    .state  (state_next),
    .result (result_next)
  );

  // Parser state: advance per character, clear after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= s1_last ? '0 : state_next;
    end
  end

  // Result register: load on a last character, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (s1_advance && s1_last) begin
      results.valid_res  <= result_next.valid_res;
      results.address    <= result_next.address;
      results.prefix_len <= result_next.prefix_len;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cidr_checker.sv =====
// Port-level checks for ipv4_cidr_validator_core, with the bind that attaches them.
// Depends on ipv4_cidr_validator_core and its channel interfaces.
`default_nettype none

module cidr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_last,
  input wire        out_valid,
  input wire        out_ready,
  input wire        valid_res,
  input wire [31:0] address,
  input wire [5:0]  prefix_len
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(address)
                                && $stable(prefix_len))
    else $error("result word changed while stalled");

  // A rejected text reports zero address and prefix
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> (address == 32'h0) && (prefix_len == 6'd0))
    else $error("invalid result carries nonzero fields");

  // An accepted text has a nonzero address and a prefix in 1..32
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> (address != 32'h0) && (prefix_len >= 6'd1)
                               && (prefix_len <= 6'd32))
    else $error("valid result out of range");

  // A fresh result follows a taken last character
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a preceding last character");

endmodule

bind ipv4_cidr_validator_core cidr_checker u_cidr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .in_last    (chars.is_last),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .valid_res  (results.valid_res),
  .address    (results.address),
  .prefix_len (results.prefix_len)
);

`default_nettype wire
